// File: hdl/mcw_pkg.sv
// ----------------------------------------------------------------------------
// mcw_pkg: shared types and constants for the corner weight unit
// Field widths, register indexes and the word that travels the cell chain.
// ----------------------------------------------------------------------------
package mcw_pkg;

    localparam int FIELD_DIMS       = 4;
    localparam int DEFAULT_MAX_DIMS = 4;
    localparam int IDX_W            = 8;
    localparam int FRAC_W           = 16;
    localparam int STRIDE_W         = 20;
    localparam int ADDR_W           = 30;
    localparam int WEIGHT_W         = 17;
    localparam int DIMS_W           = 3;
    localparam int CFG_IDX_W        = 3;

    localparam logic [WEIGHT_W-1:0] ONE_Q16 = WEIGHT_W'(17'h10000);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_3 = 3'd4;

    typedef logic [FIELD_DIMS-1:0][IDX_W-1:0]    idx_vec_t;
    typedef logic [FIELD_DIMS-1:0][FRAC_W-1:0]   frac_vec_t;
    typedef logic [FIELD_DIMS-1:0][STRIDE_W-1:0] stride_vec_t;

    // one corner in flight through the chain
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [DIMS_W-1:0]     dims;
        logic [FIELD_DIMS-1:0] corner;
        logic [ADDR_W-1:0]     addr;
        logic [WEIGHT_W-1:0]   weight;
        idx_vec_t              idx;
        frac_vec_t             frac;
    } word_t;

endpackage

// File: hdl/multilinear_corner_weights_unit.sv
// ----------------------------------------------------------------------------
// multilinear_corner_weights_unit: multilinear interpolation corner weights
// Expands one query into the addresses and weights of its cell corners.
// ----------------------------------------------------------------------------
// A query (grid_index_*, frac_*) is taken at a clock edge with start high
// and busy low. It yields 2^D corner words in ascending corner order, one
// per cycle, each shown for one cycle with done high; last_corner marks the
// final word. D is num_dims, capped at the number of cells.
// A query's first word is registered in the sequencer, then in each cell.
// Throughput: one corner word per cycle; a query holds the sequencer until
// its 2^D words (1 to 16) are issued, and the next query is taken in the cycle that
// issues the last corner, so queries follow with no gap.
// The chain has one cell per dimension; each corner passes through all of
// them, one multiply-accumulate of address and weight per cell below D.
// The receiver cannot stall: done words must be taken when shown.
// Configuration: cfg_valid/cfg_ready (always ready) write cfg_data into
// register cfg_index; unknown indexes are dropped. Write only while idle.
// Reset clears the sequencer and chain, num_dims to 1, strides to 1,0,0,0.
// ----------------------------------------------------------------------------
module multilinear_corner_weights_unit #(
    parameter int MAX_DIMS = mcw_pkg::DEFAULT_MAX_DIMS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [mcw_pkg::IDX_W-1:0]     grid_index_0,
    input  logic [mcw_pkg::IDX_W-1:0]     grid_index_1,
    input  logic [mcw_pkg::IDX_W-1:0]     grid_index_2,
    input  logic [mcw_pkg::IDX_W-1:0]     grid_index_3,
    input  logic [mcw_pkg::FRAC_W-1:0]    frac_0,
    input  logic [mcw_pkg::FRAC_W-1:0]    frac_1,
    input  logic [mcw_pkg::FRAC_W-1:0]    frac_2,
    input  logic [mcw_pkg::FRAC_W-1:0]    frac_3,
    output logic                          done,
    output logic [mcw_pkg::ADDR_W-1:0]    corner_address,
    output logic [mcw_pkg::WEIGHT_W-1:0]  corner_weight,
    output logic                          last_corner,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcw_pkg::STRIDE_W-1:0]  cfg_data
);

    localparam int NCELL = (MAX_DIMS < mcw_pkg::FIELD_DIMS) ? MAX_DIMS
                                                           : mcw_pkg::FIELD_DIMS;

    logic [mcw_pkg::DIMS_W-1:0]  num_dims_reg;
    mcw_pkg::stride_vec_t        stride_reg;
    logic [mcw_pkg::DIMS_W-1:0]  dims_used;
    mcw_pkg::idx_vec_t           idx_in;
    mcw_pkg::frac_vec_t          frac_in;
    mcw_pkg::word_t              chain [0:NCELL];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg  <= mcw_pkg::DIMS_W'(1);
            stride_reg[0] <= mcw_pkg::STRIDE_W'(1);
            stride_reg[1] <= '0;
            stride_reg[2] <= '0;
            stride_reg[3] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mcw_pkg::REG_NUM_DIMS: num_dims_reg  <= cfg_data[mcw_pkg::DIMS_W-1:0];
                mcw_pkg::REG_STRIDE_0: stride_reg[0] <= cfg_data;
                mcw_pkg::REG_STRIDE_1: stride_reg[1] <= cfg_data;
                mcw_pkg::REG_STRIDE_2: stride_reg[2] <= cfg_data;
                mcw_pkg::REG_STRIDE_3: stride_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // cap at the number of cells built
    assign dims_used = (num_dims_reg > mcw_pkg::DIMS_W'(NCELL))
                     ? mcw_pkg::DIMS_W'(NCELL) : num_dims_reg;

    assign idx_in  = {grid_index_3, grid_index_2, grid_index_1, grid_index_0};
    assign frac_in = {frac_3, frac_2, frac_1, frac_0};

    mcw_seq #(
        .NCELL (NCELL)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .dims  (dims_used),
        .idx   (idx_in),
        .frac  (frac_in),
        .busy  (busy),
        .word  (chain[0])
    );

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        mcw_cell #(
            .DIM (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .stride   (stride_reg[g]),
            .in_word  (chain[g]),
            .out_word (chain[g+1])
        );
    end

    assign done           = chain[NCELL].valid;
    assign corner_address = chain[NCELL].addr;
    assign corner_weight  = chain[NCELL].weight;
    assign last_corner    = chain[NCELL].last;

`ifndef SYNTH
    // an accepted query shows its first corner word after the chain delay
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##NCELL done)
        else $error("first corner word missing after query accept");

    // a weight never exceeds one
    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (corner_weight <= mcw_pkg::ONE_Q16))
        else $error("corner weight above one");

    // busy only while a query is being issued
    a_busy_active: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> chain[0].valid && !chain[0].last)
        else $error("busy without a query in flight");
`endif

endmodule

// File: hdl/mcw_seq.sv
// ----------------------------------------------------------------------------
// mcw_seq: corner sequencer
// Holds one query and issues its 2^D corner words, one per cycle.
// ----------------------------------------------------------------------------
module mcw_seq #(
    parameter int NCELL = mcw_pkg::DEFAULT_MAX_DIMS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mcw_pkg::DIMS_W-1:0] dims,
    input  mcw_pkg::idx_vec_t         idx,
    input  mcw_pkg::frac_vec_t        frac,
    output logic                      busy,
    output mcw_pkg::word_t            word
);

    logic                        active_reg;
    logic [NCELL-1:0]            k_reg;
    logic [NCELL-1:0]            last_k_reg;
    logic [NCELL-1:0]            last_k_next;
    logic [mcw_pkg::DIMS_W-1:0]  dims_reg;
    mcw_pkg::idx_vec_t           idx_reg;
    mcw_pkg::frac_vec_t          frac_reg;
    logic                        accept;
    logic                        at_last;

    assign at_last     = (k_reg == last_k_reg);
    assign busy        = active_reg && !at_last;
    assign accept      = start && !busy;
    // all ones below bit dims
    assign last_k_next = ~({NCELL{1'b1}} << dims);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
            last_k_reg <= '0;
        end
        else if (accept)
        begin
            active_reg <= 1'b1;
            k_reg      <= '0;
            last_k_reg <= last_k_next;
        end
        else if (active_reg)
        begin
            if (at_last)
            begin
                active_reg <= 1'b0;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dims_reg <= dims;
            idx_reg  <= idx;
            frac_reg <= frac;
        end
    end

    always_comb
    begin
        word        = '0;
        word.valid  = active_reg;
        word.last   = at_last;
        word.dims   = dims_reg;
        word.corner = mcw_pkg::FIELD_DIMS'(k_reg);
        word.addr   = '0;
        word.weight = mcw_pkg::ONE_Q16;
        word.idx    = idx_reg;
        word.frac   = frac_reg;
    end

endmodule

// File: hdl/mcw_cell.sv
// ----------------------------------------------------------------------------
// mcw_cell: one dimension of the corner chain
// If DIM < dims, adds its address term and scales the weight by w or 1-w.
// ----------------------------------------------------------------------------
module mcw_cell #(
    parameter int DIM = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mcw_pkg::STRIDE_W-1:0]  stride,
    input  mcw_pkg::word_t                in_word,
    output mcw_pkg::word_t                out_word
);

    localparam int TERM_W = mcw_pkg::IDX_W + 1 + mcw_pkg::STRIDE_W;
    localparam int PROD_W = 2 * mcw_pkg::WEIGHT_W;

    mcw_pkg::word_t                 word_reg;
    mcw_pkg::word_t                 word_next;
    logic                           enable;
    logic                           upper;
    logic [mcw_pkg::WEIGHT_W-1:0]   factor;
    logic [mcw_pkg::IDX_W:0]        pos;
    logic [TERM_W-1:0]              term;
    logic [PROD_W-1:0]              prod;

    always_comb
    begin
        enable = (mcw_pkg::DIMS_W'(DIM) < in_word.dims);
        upper  = in_word.corner[DIM];
        factor = upper ? mcw_pkg::WEIGHT_W'(in_word.frac[DIM])
                       : mcw_pkg::ONE_Q16 - mcw_pkg::WEIGHT_W'(in_word.frac[DIM]);
        pos    = (mcw_pkg::IDX_W + 1)'(in_word.idx[DIM]) + (mcw_pkg::IDX_W + 1)'(upper);
        term   = TERM_W'(pos) * TERM_W'(stride);
        prod   = PROD_W'(in_word.weight) * PROD_W'(factor);

        word_next = in_word;
        if (enable)
        begin
            word_next.addr   = in_word.addr + mcw_pkg::ADDR_W'(term);
            // truncating q16 product
            word_next.weight = prod[16 +: mcw_pkg::WEIGHT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign out_word = word_reg;

endmodule

// File: bench/tb_multilinear_corner_weights_unit.sv
// ----------------------------------------------------------------------------
// tb_multilinear_corner_weights_unit: self-checking bench for the corner unit
// Sends grid queries under several register settings and predicts every
// corner word (address, weight, last flag) in ascending corner order.
// ----------------------------------------------------------------------------
typedef struct {
    logic [mcw_pkg::ADDR_W-1:0]   addr;
    logic [mcw_pkg::WEIGHT_W-1:0] weight;
    logic                         last;
} corner_word_t;

class corner_scoreboard;
    int unsigned                max_dims;
    logic [mcw_pkg::DIMS_W-1:0] dims_reg;
    mcw_pkg::stride_vec_t       stride_reg;
    corner_word_t               expected_corners[$];
    int unsigned                mismatches;
    int unsigned                queries_noted;
    int unsigned                corners_checked;

    function new(int unsigned max_dims_cfg);
        max_dims        = max_dims_cfg;
        dims_reg        = mcw_pkg::DIMS_W'(1);
        stride_reg      = '0;
        stride_reg[0]   = mcw_pkg::STRIDE_W'(1);
        mismatches      = 0;
        queries_noted   = 0;
        corners_checked = 0;
    endfunction

    function void write_reg(logic [mcw_pkg::CFG_IDX_W-1:0] index,
                            logic [mcw_pkg::STRIDE_W-1:0] data);
        if (index == mcw_pkg::REG_NUM_DIMS)
        begin
            dims_reg = data[mcw_pkg::DIMS_W-1:0];
        end
        else if (index >= mcw_pkg::REG_STRIDE_0 && index <= mcw_pkg::REG_STRIDE_3)
        begin
            stride_reg[2'(index - mcw_pkg::REG_STRIDE_0)] = data;
        end
        // other indexes are dropped by the unit
    endfunction

    // expand one accepted query into its corner words
    function void note_query(mcw_pkg::idx_vec_t idx, mcw_pkg::frac_vec_t frac);
        int unsigned   dims;
        int unsigned   count;
        int unsigned   k;
        int unsigned   i;
        logic          upper;
        logic [16:0]   factor;
        logic [63:0]   addr_sum;
        logic [63:0]   w;
        corner_word_t  c;
        dims = dims_reg;
        if (dims > max_dims)
        begin
            dims = max_dims;
        end
        if (dims > mcw_pkg::FIELD_DIMS)
        begin
            dims = mcw_pkg::FIELD_DIMS;
        end
        count = 1 << dims;
        for (k = 0; k < count; k++)
        begin
            addr_sum = '0;
            w        = 64'(mcw_pkg::ONE_Q16);
            for (i = 0; i < dims; i++)
            begin
                upper    = ((k >> i) & 1) != 0;
                factor   = upper ? {1'b0, frac[i]} : (mcw_pkg::ONE_Q16 - {1'b0, frac[i]});
                addr_sum = addr_sum + (64'(idx[i]) + 64'(upper)) * 64'(stride_reg[i]);
                w        = (w * 64'(factor)) >> 16;
            end
            c.addr   = addr_sum[mcw_pkg::ADDR_W-1:0];
            c.weight = w[mcw_pkg::WEIGHT_W-1:0];
            c.last   = (k + 1 == count);
            expected_corners.push_back(c);
        end
        queries_noted++;
    endfunction

    task report_mismatch(string what);
        if (mismatches < 30)
        begin
            $display("mismatch: %s", what);
        end
        mismatches++;
    endtask

    task check_corner(logic [mcw_pkg::ADDR_W-1:0] addr,
                      logic [mcw_pkg::WEIGHT_W-1:0] weight, logic last);
        corner_word_t exp_c;
        if (expected_corners.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word addr=%0d weight=%0d last=%0b",
                                      addr, weight, last));
            return;
        end
        exp_c = expected_corners.pop_front();
        corners_checked++;
        if (addr !== exp_c.addr)
        begin
            report_mismatch($sformatf("word %0d address got %0d want %0d",
                                      corners_checked, addr, exp_c.addr));
        end
        if (weight !== exp_c.weight)
        begin
            report_mismatch($sformatf("word %0d weight got %0d want %0d",
                                      corners_checked, weight, exp_c.weight));
        end
        if (last !== exp_c.last)
        begin
            report_mismatch($sformatf("word %0d last_corner got %0b want %0b",
                                      corners_checked, last, exp_c.last));
        end
    endtask
endclass

module tb_multilinear_corner_weights_unit;

    localparam int MAX_DIMS       = mcw_pkg::DEFAULT_MAX_DIMS;
    localparam int LIMIT_CYCLES   = 400000;
    localparam int SETTLE_CYCLES  = MAX_DIMS + 8;
    localparam int RANDOM_QUERIES = 170;
    localparam int FIRST_QUERIES  = 6;

    // indexes the unit does not decode
    localparam logic [mcw_pkg::CFG_IDX_W-1:0] SPARE_INDEX_LO  = 3'd5;
    localparam logic [mcw_pkg::CFG_IDX_W-1:0] SPARE_INDEX_MID = 3'd6;
    localparam logic [mcw_pkg::CFG_IDX_W-1:0] SPARE_INDEX_HI  = 3'd7;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          start        = 1'b0;
    logic                          busy;
    logic [mcw_pkg::IDX_W-1:0]     grid_index_0 = '0;
    logic [mcw_pkg::IDX_W-1:0]     grid_index_1 = '0;
    logic [mcw_pkg::IDX_W-1:0]     grid_index_2 = '0;
    logic [mcw_pkg::IDX_W-1:0]     grid_index_3 = '0;
    logic [mcw_pkg::FRAC_W-1:0]    frac_0       = '0;
    logic [mcw_pkg::FRAC_W-1:0]    frac_1       = '0;
    logic [mcw_pkg::FRAC_W-1:0]    frac_2       = '0;
    logic [mcw_pkg::FRAC_W-1:0]    frac_3       = '0;
    logic                          done;
    logic [mcw_pkg::ADDR_W-1:0]    corner_address;
    logic [mcw_pkg::WEIGHT_W-1:0]  corner_weight;
    logic                          last_corner;
    logic                          cfg_valid    = 1'b0;
    logic                          cfg_ready;
    logic [mcw_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic [mcw_pkg::STRIDE_W-1:0]  cfg_data     = '0;

    int unsigned      cycle_count     = 0;
    int unsigned      settings_loaded = 0;
    corner_scoreboard sb;

    multilinear_corner_weights_unit #(
        .MAX_DIMS(MAX_DIMS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .grid_index_0  (grid_index_0),
        .grid_index_1  (grid_index_1),
        .grid_index_2  (grid_index_2),
        .grid_index_3  (grid_index_3),
        .frac_0        (frac_0),
        .frac_1        (frac_1),
        .frac_2        (frac_2),
        .frac_3        (frac_3),
        .done          (done),
        .corner_address(corner_address),
        .corner_weight (corner_weight),
        .last_corner   (last_corner),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // every word shown with done is taken at this edge
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            sb.check_corner(corner_address, corner_weight, last_corner);
        end
    end

    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_count);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [mcw_pkg::IDX_W-1:0] pick_index();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            return '0;
        end
        if (r < 30)
        begin
            return '1;
        end
        return mcw_pkg::IDX_W'($urandom);
    endfunction

    function automatic logic [mcw_pkg::FRAC_W-1:0] pick_frac();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return '0;
        end
        if (r < 20)
        begin
            return '1;
        end
        if (r < 25)
        begin
            return mcw_pkg::FRAC_W'(16'h8000);
        end
        if (r < 30)
        begin
            return mcw_pkg::FRAC_W'(1);
        end
        return mcw_pkg::FRAC_W'($urandom);
    endfunction

    function automatic mcw_pkg::stride_vec_t pick_strides();
        mcw_pkg::stride_vec_t s;
        int unsigned          r;
        for (int i = 0; i < mcw_pkg::FIELD_DIMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 20)
            begin
                s[i] = '1;
            end
            else if (r < 35)
            begin
                s[i] = '0;
            end
            else if (r < 50)
            begin
                s[i] = mcw_pkg::STRIDE_W'($urandom_range(1, 16));
            end
            else
            begin
                s[i] = mcw_pkg::STRIDE_W'($urandom);
            end
        end
        return s;
    endfunction

    // num_dims word with junk above the three decoded bits
    function automatic logic [mcw_pkg::STRIDE_W-1:0] dims_word(int unsigned dims);
        logic [mcw_pkg::STRIDE_W-1:0] data;
        data                        = mcw_pkg::STRIDE_W'($urandom);
        data[mcw_pkg::DIMS_W-1:0]   = mcw_pkg::DIMS_W'(dims);
        return data;
    endfunction

    task automatic drive_fields(mcw_pkg::idx_vec_t idx, mcw_pkg::frac_vec_t frac);
        grid_index_0 <= idx[0];
        grid_index_1 <= idx[1];
        grid_index_2 <= idx[2];
        grid_index_3 <= idx[3];
        frac_0       <= frac[0];
        frac_1       <= frac[1];
        frac_2       <= frac[2];
        frac_3       <= frac[3];
    endtask

    task automatic send_query(mcw_pkg::idx_vec_t idx, mcw_pkg::frac_vec_t frac);
        start <= 1'b1;
        drive_fields(idx, frac);
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        sb.note_query(idx, frac);
    endtask

    task automatic send_random_query();
        mcw_pkg::idx_vec_t  idx;
        mcw_pkg::frac_vec_t frac;
        for (int i = 0; i < mcw_pkg::FIELD_DIMS; i++)
        begin
            idx[i]  = pick_index();
            frac[i] = pick_frac();
        end
        send_query(idx, frac);
    endtask

    // sender gap with noise on the fields while start is low
    task automatic idle_sender(int unsigned cycles);
        if (cycles == 0)
        begin
            return;
        end
        start <= 1'b0;
        drive_fields(mcw_pkg::idx_vec_t'($urandom),
                     mcw_pkg::frac_vec_t'({$urandom, $urandom}));
        repeat (cycles) @(posedge clk);
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic wait_for_corners();
        start <= 1'b0;
        while (sb.expected_corners.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [mcw_pkg::CFG_IDX_W-1:0] index,
                             logic [mcw_pkg::STRIDE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(index, data);
    endtask

    task automatic cfg_idle();
        cfg_valid <= 1'b0;
        cfg_index <= mcw_pkg::CFG_IDX_W'($urandom);
        cfg_data  <= mcw_pkg::STRIDE_W'($urandom);
        @(posedge clk);
    endtask

    task automatic load_settings(logic [mcw_pkg::STRIDE_W-1:0] dims_data,
                                 mcw_pkg::stride_vec_t strides);
        write_reg(mcw_pkg::REG_NUM_DIMS, dims_data);
        for (int i = 0; i < mcw_pkg::FIELD_DIMS; i++)
        begin
            write_reg(mcw_pkg::CFG_IDX_W'(mcw_pkg::REG_STRIDE_0 + i), strides[i]);
        end
        cfg_idle();
        settings_loaded++;
    endtask

    initial
    begin
        int unsigned burst_len;
        int unsigned sent;
        int unsigned plan_step;
        sb        = new(MAX_DIMS);
        sent      = 0;
        plan_step = 0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a few queries under the reset register values
        repeat (FIRST_QUERIES)
        begin
            send_random_query();
            sent++;
            idle_sender(pick_gap());
        end
        wait_for_corners();

        while (sent < RANDOM_QUERIES)
        begin
            case (plan_step % 3)
                0: write_reg(SPARE_INDEX_LO, mcw_pkg::STRIDE_W'($urandom));
                1: write_reg(SPARE_INDEX_MID, mcw_pkg::STRIDE_W'($urandom));
                default: write_reg(SPARE_INDEX_HI, mcw_pkg::STRIDE_W'($urandom));
            endcase
            // num_dims walks through every code, including those above the cap
            load_settings(dims_word(plan_step % 8), pick_strides());
            burst_len = $urandom_range(8, 16);
            for (int q = 0; q < burst_len; q++)
            begin
                if (sent >= RANDOM_QUERIES)
                begin
                    break;
                end
                send_random_query();
                sent++;
                idle_sender(pick_gap());
            end
            wait_for_corners();
            plan_step++;
        end

        $display("ran %0d queries and checked %0d corner words under %0d register settings,",
                 sb.queries_noted, sb.corners_checked, settings_loaded + 1);
        $display("with back-to-back and gapped queries and every num_dims code");
        if (sb.mismatches == 0 && sb.expected_corners.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/mcw_pkg.sv
hdl/mcw_seq.sv
hdl/mcw_cell.sv
hdl/multilinear_corner_weights_unit.sv
bench/tb_multilinear_corner_weights_unit.sv
